// ===== design/sil_pkg.sv =====
package sil_pkg;

  localparam int MaxIntervals = 1024;
  localparam int IdxW = $clog2(MaxIntervals);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_HASH_MISS = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_HASH    = 2'd0,
    MODE_KEYLESS = 2'd1,
    MODE_RANGE   = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_SHARD_COUNT    = 2'd0,
    CFG_TABLE_MODE     = 2'd1,
    CFG_UNIFORM_RANGES = 2'd2,
    CFG_NONE           = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_WRITE  = 2'd0,
    JOB_DIRECT = 2'd1,
    JOB_SEARCH = 2'd2,
    JOB_DIVIDE = 2'd3
  } job_kind_t;

  // classified work handed from front to back
  typedef struct packed {
    job_kind_t         kind;
    logic [IdxW-1:0]   index;
    status_t           status;
    status_t           miss_status;
    logic [CntW-1:0]   count;
    logic [KeyW-1:0]   key;
    logic [KeyW-1:0]   low;
    logic [KeyW-1:0]   high;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_DIVR,
    BK_DIVQ,
    BK_DONE
  } back_state_t;

  localparam int QDepth = 2;

endpackage

// ===== design/shard_interval_lookup.sv =====
// Shard interval lookup.
// s_axis carries one word per item: tdata = {search_key, entry_high,
// entry_low, entry_index, opcode}. Opcode 0 writes an interval into the
// table, opcode 1 looks up search_key. m_axis returns one word per item,
// tdata = {status, shard_index}.
// cfg writes shard_count (0), table_mode (1) and uniform_ranges (2); the user
// must make these writes only while idle, as the block does not enforce it.
// Items pass through a two-entry queue after classification; the back end
// handles one item at a time. Write, empty-table and keyless items go from
// idle straight to the result state. A binary search spends a read state and
// a compare state per probe against the table RAMs (registered read). Uniform
// hash mode runs two 33-step restoring divisions on one shared divider.
// Reset clears the cfg registers, the queue and the controller; table contents
// stay undefined until written. A stalled m_axis holds the result; the queue
// keeps accepting until it is full.
module shard_interval_lookup (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[0], entry_index[10:1], entry_low[74:11], entry_high[138:75],
  // search_key[202:139], zero fill to 208
  input  logic [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // shard_index[9:0], status[11:10], zero fill to 16
  output logic [15:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [sil_pkg::CntW-1:0]  shard_count;
  sil_pkg::mode_t            table_mode;
  logic                      uniform_ranges;
  logic                      job_valid, job_ready;
  sil_pkg::job_t             job;
  logic [sil_pkg::IdxW-1:0]  raddr;
  logic [sil_pkg::KeyW-1:0]  low_rd, high_rd;
  logic                      we;
  logic [sil_pkg::IdxW-1:0]  waddr;
  logic [sil_pkg::KeyW-1:0]  wlow, whigh;
  logic [sil_pkg::IdxW-1:0]  shard_index;
  sil_pkg::status_t          status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shard_count    <= '0;
      table_mode     <= sil_pkg::MODE_HASH;
      uniform_ranges <= 1'b0;
    end else if (cfg_valid) begin
      unique case (sil_pkg::cfg_reg_t'(cfg_index))
        sil_pkg::CFG_SHARD_COUNT:    shard_count <= cfg_data[sil_pkg::CntW-1:0];
        sil_pkg::CFG_TABLE_MODE:     table_mode <= sil_pkg::mode_t'(cfg_data[1:0]);
        sil_pkg::CFG_UNIFORM_RANGES: uniform_ranges <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sil_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .opcode(s_axis_tdata[0]), .entry_index(s_axis_tdata[10:1]),
    .entry_low(s_axis_tdata[74:11]), .entry_high(s_axis_tdata[138:75]),
    .search_key(s_axis_tdata[202:139]),
    .shard_count, .table_mode, .uniform_ranges,
    .job_valid, .job_ready, .job
  );

  sil_ram #(.Width(sil_pkg::KeyW), .Depth(sil_pkg::MaxIntervals)) u_low (
    .clk, .we, .waddr, .wdata(wlow),
    .raddr, .rdata(low_rd)
  );

  sil_ram #(.Width(sil_pkg::KeyW), .Depth(sil_pkg::MaxIntervals)) u_high (
    .clk, .we, .waddr, .wdata(whigh),
    .raddr, .rdata(high_rd)
  );

  sil_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .we, .waddr, .wlow, .whigh,
    .raddr, .low_rd, .high_rd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .shard_index, .status
  );

  assign m_axis_tdata = {4'd0, status, shard_index};

endmodule

// ===== design/sil_ram.sv =====
module sil_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sil_front.sv =====
module sil_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [sil_pkg::IdxW-1:0]        entry_index,
  input  logic [sil_pkg::KeyW-1:0]        entry_low,
  input  logic [sil_pkg::KeyW-1:0]        entry_high,
  input  logic [sil_pkg::KeyW-1:0]        search_key,
  input  logic [sil_pkg::CntW-1:0]        shard_count,
  input  sil_pkg::mode_t                  table_mode,
  input  logic                            uniform_ranges,
  output logic                            job_valid,
  input  logic                            job_ready,
  output sil_pkg::job_t                   job
);

  sil_pkg::job_t            q [sil_pkg::QDepth];
  logic                     wptr;
  logic                     rptr;
  logic [1:0]               fill;
  sil_pkg::job_t            cls;
  logic [sil_pkg::CntW-1:0] cnt;
  logic                     push;
  logic                     pop;

  assign in_ready  = (fill != 2'(sil_pkg::QDepth));
  assign job_valid = (fill != 2'd0);
  assign job       = q[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_comb begin
    cnt = (shard_count > sil_pkg::CntW'(sil_pkg::MaxIntervals)) ?
          sil_pkg::CntW'(sil_pkg::MaxIntervals) : shard_count;
    cls.index       = '0;
    cls.count       = cnt;
    cls.key         = search_key;
    cls.low         = entry_low;
    cls.high        = entry_high;
    cls.status      = sil_pkg::ST_OK;
    cls.miss_status = sil_pkg::ST_NOT_FOUND;
    cls.kind        = sil_pkg::JOB_DIRECT;
    if (!opcode) begin
      cls.kind  = sil_pkg::JOB_WRITE;
      cls.index = entry_index;
    end else if (cnt == '0) begin
      cls.status = sil_pkg::ST_EMPTY;
    end else if (table_mode == sil_pkg::MODE_HASH) begin
      cls.miss_status = sil_pkg::ST_HASH_MISS;
      cls.kind = uniform_ranges ? sil_pkg::JOB_DIVIDE : sil_pkg::JOB_SEARCH;
    end else if (table_mode != sil_pkg::MODE_KEYLESS) begin
      cls.kind = sil_pkg::JOB_SEARCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
    if (push) begin
      q[wptr] <= cls;
    end
  end

endmodule

// ===== design/sil_back.sv =====
module sil_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  sil_pkg::job_t              job,
  output logic                       we,
  output logic [sil_pkg::IdxW-1:0]   waddr,
  output logic [sil_pkg::KeyW-1:0]   wlow,
  output logic [sil_pkg::KeyW-1:0]   whigh,
  output logic [sil_pkg::IdxW-1:0]   raddr,
  input  logic [sil_pkg::KeyW-1:0]   low_rd,
  input  logic [sil_pkg::KeyW-1:0]   high_rd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sil_pkg::IdxW-1:0]   shard_index,
  output sil_pkg::status_t           status
);

  sil_pkg::back_state_t     state, state_next;
  sil_pkg::job_t            cur;
  logic [sil_pkg::CntW-1:0] lo, hi;
  logic [sil_pkg::CntW-1:0] mid;
  logic [32:0]              rem;
  logic [32:0]              divisor;
  logic [32:0]              quo;
  logic [5:0]               step;
  logic [33:0]              trial;
  logic                     key_lt_low;
  logic                     high_lt_key;
  logic                     res_load;
  logic [sil_pkg::IdxW-1:0] res_idx;
  sil_pkg::status_t         res_st;
  logic [sil_pkg::CntW-1:0] qclamp;

  assign mid        = sil_pkg::CntW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign raddr      = mid[sil_pkg::IdxW-1:0];
  assign key_lt_low = $signed(cur.key) < $signed(low_rd);
  assign high_lt_key = $signed(high_rd) < $signed(cur.key);
  assign trial      = {rem, quo[32]} - {1'b0, divisor};
  assign qclamp     = (quo >= 33'(cur.count)) ? cur.count - 1'b1 :
                      quo[sil_pkg::CntW-1:0];
  assign job_ready  = (state == sil_pkg::BK_IDLE);

  // commit a table write when its word is taken, so lookups see items in order
  assign we    = job_ready && job_valid && (job.kind == sil_pkg::JOB_WRITE);
  assign waddr = job.index;
  assign wlow  = job.low;
  assign whigh = job.high;

  always_comb begin
    state_next = state;
    res_load   = 1'b0;
    res_idx    = '0;
    res_st     = sil_pkg::ST_OK;
    unique case (state)
      sil_pkg::BK_IDLE: begin
        if (job_valid) begin
          if (job.kind == sil_pkg::JOB_SEARCH) begin
            state_next = sil_pkg::BK_READ;
          end else if (job.kind == sil_pkg::JOB_DIVIDE) begin
            state_next = sil_pkg::BK_DIVR;
          end else begin
            state_next = sil_pkg::BK_DONE;
          end
        end
      end
      sil_pkg::BK_READ: begin
        if (lo < hi) begin
          state_next = sil_pkg::BK_CMP;
        end else begin
          state_next = sil_pkg::BK_DONE;
          res_load   = 1'b1;
          res_st     = cur.miss_status;
        end
      end
      sil_pkg::BK_CMP: begin
        if (!key_lt_low && !high_lt_key) begin
          state_next = sil_pkg::BK_DONE;
          res_load   = 1'b1;
          res_idx    = raddr;
        end else begin
          state_next = sil_pkg::BK_READ;
        end
      end
      sil_pkg::BK_DIVR: begin
        if (step == 6'd33) begin
          state_next = sil_pkg::BK_DIVQ;
        end
      end
      sil_pkg::BK_DIVQ: begin
        if (step == 6'd33) begin
          state_next = sil_pkg::BK_DONE;
          res_load   = 1'b1;
          res_idx    = qclamp[sil_pkg::IdxW-1:0];
        end
      end
      sil_pkg::BK_DONE: begin
        if (out_ready) begin
          state_next = sil_pkg::BK_IDLE;
        end
      end
      default: state_next = sil_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sil_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_valid = (state == sil_pkg::BK_DONE);

  // restoring division: first 2^32 / count for the range, then norm / range
  always_ff @(posedge clk) begin
    unique case (state)
      sil_pkg::BK_IDLE: begin
        cur         <= job;
        lo          <= '0;
        hi          <= job.count;
        step        <= '0;
        rem         <= '0;
        quo         <= {1'b1, 32'd0};
        divisor     <= 33'(job.count);
        shard_index <= job.index;
        status      <= job.status;
      end
      sil_pkg::BK_CMP: begin
        if (key_lt_low) begin
          hi <= mid;
        end else begin
          lo <= mid + 1'b1;
        end
      end
      sil_pkg::BK_DIVR, sil_pkg::BK_DIVQ: begin
        if (step == 6'd33) begin
          step    <= '0;
          rem     <= '0;
          divisor <= quo;
          quo     <= {1'b0, cur.key[31] ^ 1'b1, cur.key[30:0]};
        end else begin
          step <= step + 1'b1;
          if (!trial[33]) begin
            rem <= trial[32:0];
            quo <= {quo[31:0], 1'b1};
          end else begin
            rem <= {rem[31:0], quo[32]};
            quo <= {quo[31:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
    if (res_load) begin
      shard_index <= res_idx;
      status      <= res_st;
    end
  end

endmodule

// ===== design/sil_checker.sv =====
module sil_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [15:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
    else $error("nonzero fill bits");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[11:10] != 2'd0 |-> m_axis_tdata[9:0] == 10'd0)
    else $error("nonzero index on a miss");

  a_ready_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(s_axis_tready))
    else $error("input ready unknown");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind shard_interval_lookup sil_checker u_sil_checker (.*);

// ===== test/lookup_checker.sv =====
module lookup_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [207:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [sil_pkg::IdxW-1:0] shard_index;
    sil_pkg::status_t         status;
  } reply_t;

  logic signed [sil_pkg::KeyW-1:0] low_bound [sil_pkg::MaxIntervals];
  logic signed [sil_pkg::KeyW-1:0] high_bound [sil_pkg::MaxIntervals];
  logic [sil_pkg::CntW-1:0] shard_count;
  sil_pkg::mode_t           table_mode;
  logic                     uniform_ranges;
  reply_t                   expected_replies[$];
  int                       fails;

  initial begin
    fails = 0;
  end

  // signed binary search over the first n entries
  function automatic bit search_table(logic signed [63:0] key, int n, output int hit);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n;
    hit = 0;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key < low_bound[mid]) begin
        hi = mid;
      end else if (!(high_bound[mid] < key)) begin
        hit = mid;
        return 1;
      end else begin
        lo = mid + 1;
      end
    end
    return 0;
  endfunction

  function automatic reply_t compute_reply(logic [207:0] word);
    reply_t r;
    logic signed [63:0] key;
    logic [63:0] norm;
    logic [63:0] span;
    logic [63:0] q;
    int n;
    int hit;
    r.shard_index = '0;
    r.status = sil_pkg::ST_OK;
    if (word[0] == 1'b0) begin
      r.shard_index = word[10:1];
      low_bound[word[10:1]] = word[74:11];
      high_bound[word[10:1]] = word[138:75];
      return r;
    end
    key = word[202:139];
    n = (shard_count > sil_pkg::MaxIntervals) ? sil_pkg::MaxIntervals : int'(shard_count);
    if (n == 0) begin
      r.status = sil_pkg::ST_EMPTY;
    end else if (table_mode == sil_pkg::MODE_HASH && uniform_ranges) begin
      norm = {32'd0, key[31:0] ^ 32'h8000_0000};
      span = 64'h1_0000_0000 / 64'(n);
      q = norm / span;
      if (q >= 64'(n)) q = 64'(n - 1);
      r.shard_index = q[sil_pkg::IdxW-1:0];
    end else if (table_mode == sil_pkg::MODE_KEYLESS) begin
      r.shard_index = '0;
    end else if (search_table(key, n, hit)) begin
      r.shard_index = hit[sil_pkg::IdxW-1:0];
    end else begin
      r.status = (table_mode == sil_pkg::MODE_HASH) ? sil_pkg::ST_HASH_MISS :
                                                      sil_pkg::ST_NOT_FOUND;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      shard_count = '0;
      table_mode = sil_pkg::MODE_HASH;
      uniform_ranges = 1'b0;
      expected_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (sil_pkg::cfg_reg_t'(cfg_index))
          sil_pkg::CFG_SHARD_COUNT:    shard_count = cfg_data[sil_pkg::CntW-1:0];
          sil_pkg::CFG_TABLE_MODE:     table_mode = sil_pkg::mode_t'(cfg_data[1:0]);
          sil_pkg::CFG_UNIFORM_RANGES: uniform_ranges = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_replies.push_back(compute_reply(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          fails++;
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tdata[9:0] !== want.shard_index) begin
            $error("shard_index mismatch: expected %0d, got %0d",
                   want.shard_index, m_axis_tdata[9:0]);
            fails++;
          end
          if (m_axis_tdata[11:10] !== want.status) begin
            $error("status mismatch: expected %0d, got %0d",
                   want.status, m_axis_tdata[11:10]);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending <= expected_replies.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] KMin = 64'h8000_0000_0000_0000;
  localparam logic signed [63:0] KMax = 64'h7FFF_FFFF_FFFF_FFFF;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           fail_count;
  int           pending;

  int tx_idle = 36;
  int rx_idle = 68;
  bit hold_go = 0;
  int hold_left = 0;
  int cur_count = 0;

  // stimulus-side copy of the bounds, used to aim keys at intervals and gaps
  logic signed [63:0] lo_tab [sil_pkg::MaxIntervals];
  logic signed [63:0] hi_tab [sil_pkg::MaxIntervals];

  shard_interval_lookup DUT (.*);

  lookup_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #8ms;
    $display("FAIL shard_interval_lookup");
    $finish;
  end

  // receiver: random stalls plus one long hold-off while the table loads
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(bit op, logic [9:0] idx, logic [63:0] lo, logic [63:0] hi,
                      logic [63:0] key);
    // idle the sender cycle by cycle
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, key, hi, lo, idx, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_entry(int idx, logic [63:0] lo, logic [63:0] hi);
    if (idx < sil_pkg::MaxIntervals) begin
      lo_tab[idx] = lo;
      hi_tab[idx] = hi;
    end
    send(1'b0, idx[9:0], lo, hi, rand64());
  endtask

  task automatic lookup(logic [63:0] key);
    send(1'b1, 10'(rand64()), rand64(), rand64(), key);
  endtask

  // drain everything, then let the back end settle before touching registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_reg(sil_pkg::cfg_reg_t r, int v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int cnt, sil_pkg::mode_t m, bit uni);
    wait_idle();
    set_reg(sil_pkg::CFG_SHARD_COUNT, cnt);
    set_reg(sil_pkg::CFG_TABLE_MODE, m);
    set_reg(sil_pkg::CFG_UNIFORM_RANGES, uni);
    cur_count = (cnt > sil_pkg::MaxIntervals) ? sil_pkg::MaxIntervals : cnt;
  endtask

  // sorted intervals with gaps, pinned to the key extremes at both ends
  task automatic load_table();
    logic signed [63:0] step;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    step = 64'h0040_0000_0000_0000;
    for (int i = 0; i < sil_pkg::MaxIntervals; i++) begin
      lo = KMin + step * i + 64'($urandom_range(0, 255));
      hi = lo + ({rand64()} % (step / 2));
      if (i == 0) lo = KMin;
      if (i == sil_pkg::MaxIntervals - 1) hi = KMax;
      write_entry(i, lo, hi);
      if (i == 40) hold_go = 1;
    end
  endtask

  task automatic random_items(int n);
    int i;
    logic signed [63:0] span;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          // out-of-range writes, a few (all when full) into the live table
          i = ($urandom_range(0, 3) == 0 && cur_count > 0) ?
              $urandom_range(0, cur_count - 1) : $urandom_range(cur_count, 1023);
          if (i > 1023) i = 1023;
          write_entry(i, rand64(), rand64());
        end
        1: lookup(rand64());
        2: lookup($urandom_range(0, 1) ? KMin : KMax);
        default: begin
          if (cur_count == 0) begin
            lookup(rand64());
          end else begin
            i = $urandom_range(0, cur_count - 1);
            span = hi_tab[i] - lo_tab[i];
            case ($urandom_range(0, 4))
              0: lookup(lo_tab[i]);
              1: lookup(hi_tab[i]);
              2: lookup(hi_tab[i] + 1);
              3: lookup(lo_tab[i] - 1);
              default: lookup((span < 0) ? rand64() : lo_tab[i] + (rand64() % (span + 1)));
            endcase
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table after reset
    lookup(KMin);
    lookup(KMax);
    write_entry(0, KMin, -1000);
    write_entry(1, -10, 10);
    write_entry(2, 100, KMax);
    write_entry(1023, KMax, KMin);
    configure(3, sil_pkg::MODE_RANGE, 0);
    lookup(KMin);
    lookup(-1000);
    lookup(-999);
    lookup(-10);
    lookup(10);
    lookup(50);
    lookup(KMax);
    configure(3, sil_pkg::MODE_HASH, 0);
    lookup(11);
    lookup(0);
    configure(3, sil_pkg::MODE_SPARE, 0);
    lookup(20);
    configure(1, sil_pkg::MODE_HASH, 1);
    lookup(64'h0000_0000_7FFF_FFFF);
    lookup(64'hFFFF_FFFF_8000_0000);
    configure(3, sil_pkg::MODE_HASH, 1);
    lookup(64'h1234_5678_7FFF_FFFF);
    lookup(64'h8000_0000_8000_0000);
    configure(3, sil_pkg::MODE_KEYLESS, 0);
    lookup(rand64());
    configure(0, sil_pkg::MODE_RANGE, 0);
    lookup(5);

    // sender idles more than receiver later; receiver idles more here
    configure(2047, sil_pkg::MODE_RANGE, 0);
    load_table();
    random_items(230);
    configure(1024, sil_pkg::MODE_HASH, 0);
    random_items(90);
    configure(2047, sil_pkg::MODE_HASH, 1);
    random_items(60);

    tx_idle = 68;
    rx_idle = 36;
    configure(5, sil_pkg::MODE_RANGE, 0);
    random_items(80);
    configure(1, sil_pkg::MODE_HASH, 1);
    random_items(40);
    configure(17, sil_pkg::MODE_SPARE, 0);
    random_items(80);
    configure(700, sil_pkg::MODE_KEYLESS, 1);
    random_items(40);

    tx_idle = 0;
    rx_idle = 0;
    configure(100, sil_pkg::MODE_HASH, 0);
    random_items(120);
    configure(3, sil_pkg::MODE_HASH, 1);
    random_items(40);
    configure(0, sil_pkg::MODE_RANGE, 0);
    random_items(20);

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS shard_interval_lookup");
    end else begin
      $display("FAIL shard_interval_lookup");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sil_pkg.sv
design/sil_ram.sv
design/sil_front.sv
design/sil_back.sv
design/shard_interval_lookup.sv
design/sil_checker.sv
test/lookup_checker.sv
test/tb.sv
